[hw/rtl/deq_pkg.sv]
// Shared types and codes for the double-ended queue.
// Depends on nothing; deq_if, deq_ctrl, deq_dp and the top level import it.
package deq_pkg;

  localparam int unsigned DataWidth  = 32;
  localparam int unsigned HeldWidth  = 7;

  typedef logic [1:0]                  cmd_code_t;
  typedef logic [1:0]                  status_code_t;
  typedef logic signed [DataWidth-1:0] data_t;
  typedef logic [HeldWidth-1:0]        held_t;

  // Request command codes
  localparam cmd_code_t CMD_PUSH_LEFT  = 2'd0;
  localparam cmd_code_t CMD_PUSH_RIGHT = 2'd1;
  localparam cmd_code_t CMD_POP_LEFT   = 2'd2;
  localparam cmd_code_t CMD_POP_RIGHT  = 2'd3;

  // Response status codes
  localparam status_code_t ST_DONE  = 2'd0;
  localparam status_code_t ST_EMPTY = 2'd1;
  localparam status_code_t ST_FULL  = 2'd2;

  // Value returned by a pop on an empty queue
  localparam data_t EmptyPopValue = '1;

  // Controller to datapath commands
  typedef struct packed {
    logic take;   // request accepted this cycle: update pointers, access RAM
    logic load;   // load the response register from the pending result
  } dq_cmd_t;

endpackage

[hw/rtl/deq_if.sv]
// Request and response channel interfaces of the double-ended queue.
// Depends on deq_pkg for payload types.
interface deq_req_if import deq_pkg::*; ();
  logic      valid;
  logic      ready;
  cmd_code_t command;
  data_t     push_value;

  modport source (output valid, command, push_value, input ready);
  modport sink   (input valid, command, push_value, output ready);
endinterface

interface deq_rsp_if import deq_pkg::*; ();
  logic         valid;
  logic         ready;
  data_t        pop_value;
  status_code_t status;
  held_t        entries_held;

  modport source (output valid, pop_value, status, entries_held, input ready);
  modport sink   (input valid, pop_value, status, entries_held, output ready);
endinterface

[hw/rtl/deq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module deq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/deq_ctrl.sv]
// Controller of the double-ended queue: request handshake, response valid.
// Depends on deq_pkg for the command struct.
module deq_ctrl import deq_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    req_valid_i,
  output logic    req_ready_o,
  output logic    rsp_valid_o,
  input  logic    rsp_ready_i,
  output dq_cmd_t cmd_o
);

  localparam logic StIdle = 1'b0;
  localparam logic StBusy = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;

  // Accept a request only when no request is in flight
  assign req_ready_o = (state_q == StIdle);
  assign cmd_o.take  = req_valid_i && req_ready_o;
  // Move the pending result out once the response register is free or draining
  assign cmd_o.load  = (state_q == StBusy) && (!out_valid_q || rsp_ready_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (cmd_o.take) begin
          state_d = StBusy;
        end
      end
      StBusy: begin
        if (cmd_o.load) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Hold the response until taken, set it on load
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load) begin
      out_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign rsp_valid_o = out_valid_q;

  // Assertions
  a_take_to_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.take |=> state_q == StBusy)
    else $error("accepted request did not enter busy state");

  a_take_load_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.take && cmd_o.load))
    else $error("accept and load in the same cycle");

  a_rsp_from_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_o.load))
    else $error("response valid rose without a load");

  a_load_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> state_q == StBusy && !req_ready_o)
    else $error("load outside busy state");

endmodule

[hw/rtl/deq_dp.sv]
// Datapath of the double-ended queue: front pointer, count, slot RAM, result.
// Depends on deq_pkg and deq_ram.
module deq_dp import deq_pkg::*; #(
  parameter int unsigned DEPTH = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  dq_cmd_t      cmd_i,
  input  cmd_code_t    command_i,
  input  data_t        push_value_i,
  output data_t        pop_value_o,
  output status_code_t status_o,
  output held_t        entries_held_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = CW + 1;

  logic [AW-1:0] front_q, front_d;
  logic [CW-1:0] count_q, count_d;

  logic          full, empty;
  logic [AW-1:0] front_dec, front_inc, tail_idx, last_idx;
  logic [SW-1:0] tail_sum, last_sum;

  logic          wr_en, rd_en, pop_ok;
  logic [AW-1:0] waddr, raddr;
  status_code_t  status_c;
  data_t         rdata;

  logic          pend_pop_q;
  status_code_t  pend_status_q;
  logic [CW-1:0] pend_count_q;
  logic [CW+HeldWidth-1:0] held_ext;

  data_t         pop_value_q;
  status_code_t  status_q;
  held_t         held_q;

  // Ring positions around the front pointer
  assign full      = (count_q == CW'(DEPTH));
  assign empty     = (count_q == '0);
  assign front_dec = (front_q == '0) ? AW'(DEPTH - 1) : front_q - 1'b1;
  assign front_inc = (front_q == AW'(DEPTH - 1)) ? '0 : front_q + 1'b1;
  assign tail_sum  = SW'(front_q) + SW'(count_q);
  assign last_sum  = tail_sum - 1'b1;
  assign tail_idx  = (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH)) : AW'(tail_sum);
  assign last_idx  = (last_sum >= SW'(DEPTH)) ? AW'(last_sum - SW'(DEPTH)) : AW'(last_sum);

  // Decode the request against the current occupancy
  always_comb begin
    wr_en    = 1'b0;
    rd_en    = 1'b0;
    pop_ok   = 1'b0;
    waddr    = front_dec;
    raddr    = front_q;
    front_d  = front_q;
    count_d  = count_q;
    status_c = ST_DONE;
    unique case (command_i)
      CMD_PUSH_LEFT: begin
        if (full) begin
          status_c = ST_FULL;
        end else begin
          wr_en   = 1'b1;
          waddr   = front_dec;
          front_d = front_dec;
          count_d = count_q + 1'b1;
        end
      end
      CMD_PUSH_RIGHT: begin
        if (full) begin
          status_c = ST_FULL;
        end else begin
          wr_en   = 1'b1;
          waddr   = tail_idx;
          count_d = count_q + 1'b1;
        end
      end
      CMD_POP_LEFT: begin
        if (empty) begin
          status_c = ST_EMPTY;
        end else begin
          rd_en   = 1'b1;
          pop_ok  = 1'b1;
          raddr   = front_q;
          front_d = front_inc;
          count_d = count_q - 1'b1;
        end
      end
      CMD_POP_RIGHT: begin
        if (empty) begin
          status_c = ST_EMPTY;
        end else begin
          rd_en   = 1'b1;
          pop_ok  = 1'b1;
          raddr   = last_idx;
          count_d = count_q - 1'b1;
        end
      end
      default: status_c = ST_DONE;
    endcase
  end

  deq_ram #(
    .WIDTH (DataWidth),
    .DEPTH (DEPTH)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.take && wr_en),
    .waddr_i (waddr),
    .wdata_i (push_value_i),
    .re_i    (cmd_i.take && rd_en),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Advance pointer and count on an accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      count_q <= '0;
    end else if (cmd_i.take) begin
      front_q <= front_d;
      count_q <= count_d;
    end
  end

  // Hold the pending result while the RAM read completes
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      pend_pop_q    <= pop_ok;
      pend_status_q <= status_c;
      pend_count_q  <= count_d;
    end
  end

  assign held_ext = {{HeldWidth{1'b0}}, pend_count_q};

  // Response register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      if (pend_pop_q) begin
        pop_value_q <= rdata;
      end else if (pend_status_q == ST_EMPTY) begin
        pop_value_q <= EmptyPopValue;
      end else begin
        pop_value_q <= '0;
      end
      status_q <= pend_status_q;
      held_q   <= held_ext[HeldWidth-1:0];
    end
  end

  assign pop_value_o    = pop_value_q;
  assign status_o       = status_q;
  assign entries_held_o = held_q;

  // Assertions
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("count exceeds depth");

  a_front_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    front_q <= AW'(DEPTH - 1))
    else $error("front pointer out of range");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.take && (status_c != ST_DONE) |=> $stable(count_q) && $stable(front_q))
    else $error("rejected request changed the queue state");

endmodule

[hw/rtl/double_ended_queue.sv]
// Double-ended queue of signed 32-bit values held in a ring of DEPTH slots.
// Top level; depends on deq_pkg, deq_if, deq_ctrl, deq_dp and deq_ram.
//
// Usage:
//   req_i carries one request per handshake: command (push left, push right,
//   pop left, pop right) and push_value, which pops ignore.
//   rsp_o returns exactly one response per request, in order: pop_value
//   (popped value, all ones for a pop on an empty queue, zero for pushes),
//   status (done, pop on empty, push dropped because full) and entries_held,
//   the low 7 bits of the occupancy after the request.
//   The slot RAM's registered read data and the pending result are loaded
//   into the response register once that register is free or draining.
//   The controller holds the request side from acceptance until that load,
//   so a new request is taken only after the previous result is loaded.
//   Reset empties the queue at once (front pointer and count cleared); slot
//   contents are not cleared and need no clearing pass.
//   If the receiver stalls, the response register holds its result and one
//   more request is still accepted; that second result waits in the datapath
//   and further requests are held off until the response is taken.
module double_ended_queue import deq_pkg::*; #(
  parameter int unsigned DEPTH = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  deq_req_if.sink       req_i,
  deq_rsp_if.source     rsp_o
);

  dq_cmd_t cmd;

  deq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .cmd_o       (cmd)
  );

  deq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .command_i      (req_i.command),
    .push_value_i   (req_i.push_value),
    .pop_value_o    (rsp_o.pop_value),
    .status_o       (rsp_o.status),
    .entries_held_o (rsp_o.entries_held)
  );

endmodule

[sim/tb.sv]
// Self-checking testbench for double_ended_queue: a directed table, then random command runs.
// Each response is checked against a ring-store deque predictor.
// Depends on deq_pkg, deq_if and the double_ended_queue RTL.
module tb;
  import deq_pkg::*;

  localparam int unsigned RingDepth  = 64;
  localparam int unsigned RandItems  = 580;
  localparam int unsigned SegLen     = 80;
  localparam int unsigned StallLimit = 2000;
  localparam int unsigned MaxReports = 10;

  typedef struct packed {
    data_t        pop_value;
    status_code_t status;
    held_t        entries_held;
  } deq_rsp_t;

  typedef struct {
    cmd_code_t   cmd;
    data_t       value;
    int unsigned reps;
    bit          rnd;     // fresh random value on each repeat
    bit          fixed;   // expected response typed into the table
    deq_rsp_t    want;
  } dir_row_t;

  logic clk;
  logic rst_n;

  deq_req_if req ();
  deq_rsp_if rsp ();

  double_ended_queue #(
    .DEPTH (RingDepth)
  ) dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  // Predictor state
  data_t       ring_val [RingDepth];
  int unsigned ring_front;
  int unsigned ring_count;

  deq_rsp_t    due_rsp_q [$];
  int unsigned fail_count;
  bit          steady_run;
  int unsigned stall_cycles;
  dir_row_t    dir_tab [20];

  // Apply one command to the predictor and return the response it yields
  function automatic deq_rsp_t deque_apply(input cmd_code_t cmd, input data_t val);
    deq_rsp_t    r;
    int unsigned slot;
    r.pop_value = '0;
    r.status    = ST_DONE;
    case (cmd)
      CMD_PUSH_LEFT, CMD_PUSH_RIGHT: begin
        if (ring_count >= RingDepth) begin
          r.status = ST_FULL;
        end else if (cmd == CMD_PUSH_LEFT) begin
          ring_front = (ring_front + RingDepth - 1) % RingDepth;
          ring_val[ring_front] = val;
          ring_count++;
        end else begin
          slot = (ring_front + ring_count) % RingDepth;
          ring_val[slot] = val;
          ring_count++;
        end
      end
      default: begin
        if (ring_count == 0) begin
          r.pop_value = EmptyPopValue;
          r.status    = ST_EMPTY;
        end else if (cmd == CMD_POP_LEFT) begin
          r.pop_value = ring_val[ring_front];
          ring_front  = (ring_front + 1) % RingDepth;
          ring_count--;
        end else begin
          slot = (ring_front + ring_count - 1) % RingDepth;
          r.pop_value = ring_val[slot];
          ring_count--;
        end
      end
    endcase
    r.entries_held = held_t'(ring_count);
    return r;
  endfunction

  // Random push value, with the extremes mixed in
  function automatic data_t pick_value();
    case ($urandom_range(0, 19))
      0:       return data_t'(32'h7fff_ffff);
      1:       return data_t'(32'h8000_0000);
      2:       return '0;
      3:       return '1;
      default: return data_t'($urandom);
    endcase
  endfunction

  // Present one request, wait for its handshake, then log the response due
  task automatic send_req(input cmd_code_t cmd, input data_t val,
                          input bit use_want, input deq_rsp_t want);
    deq_rsp_t pred;
    if (!steady_run) begin
      while ($urandom_range(0, 99) < 24) begin
        req.valid      <= 1'b0;
        req.push_value <= data_t'($urandom);
        @(posedge clk);
      end
    end
    req.valid      <= 1'b1;
    req.command    <= cmd;
    req.push_value <= val;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    pred = deque_apply(cmd, val);
    due_rsp_q.push_back(use_want ? want : pred);
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Response-side backpressure
  initial begin
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rsp.ready <= steady_run || ($urandom_range(0, 99) >= 24);
    end
  end

  // Check each accepted response against the oldest one due
  initial begin
    deq_rsp_t want;
    forever begin
      @(posedge clk);
      if (rst_n && rsp.valid && rsp.ready) begin
        if (due_rsp_q.size() == 0) begin
          fail_count++;
          if (fail_count <= MaxReports)
            $display("unexpected response: pop_value %0d status %0d held %0d",
                     rsp.pop_value, rsp.status, rsp.entries_held);
        end else begin
          want = due_rsp_q.pop_front();
          if (rsp.pop_value !== want.pop_value || rsp.status !== want.status ||
              rsp.entries_held !== want.entries_held) begin
            fail_count++;
            if (fail_count <= MaxReports)
              $display("mismatch: pop_value %0d/%0d status %0d/%0d held %0d/%0d (exp/got)",
                       want.pop_value, rsp.pop_value, want.status, rsp.status,
                       want.entries_held, rsp.entries_held);
          end
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  initial begin
    stall_cycles = 0;
    forever begin
      @(posedge clk);
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= StallLimit) begin
        $display("double_ended_queue regression: fail");
        $finish;
      end
    end
  end

  // Stimulus and end of run
  initial begin
    int unsigned sent;
    int unsigned seg_left;
    int unsigned push_bias;
    cmd_code_t   cmd;

    rst_n          <= 1'b0;
    req.valid      <= 1'b0;
    req.command    <= CMD_PUSH_LEFT;
    req.push_value <= '0;
    steady_run     = 1'b0;
    fail_count     = 0;
    ring_front     = 0;
    ring_count     = 0;
    foreach (ring_val[i]) ring_val[i] = '0;

    dir_tab = '{
      // empty after reset, both ends
      '{CMD_POP_LEFT,   '0, 1, 1'b0, 1'b1, '{EmptyPopValue, ST_EMPTY, 7'd0}},
      '{CMD_POP_RIGHT,  '0, 1, 1'b0, 1'b1, '{EmptyPopValue, ST_EMPTY, 7'd0}},
      // extremes in and out of both ends
      '{CMD_PUSH_LEFT,  32'h7fff_ffff, 1, 1'b0, 1'b1, '{'0, ST_DONE, 7'd1}},
      '{CMD_PUSH_RIGHT, 32'h8000_0000, 1, 1'b0, 1'b1, '{'0, ST_DONE, 7'd2}},
      '{CMD_POP_LEFT,   '0, 1, 1'b0, 1'b1, '{32'h7fff_ffff, ST_DONE, 7'd1}},
      '{CMD_POP_RIGHT,  '0, 1, 1'b0, 1'b1, '{32'h8000_0000, ST_DONE, 7'd0}},
      // a stored all-ones value is told apart from an empty pop by status
      '{CMD_PUSH_RIGHT, '1, 1, 1'b0, 1'b1, '{'0, ST_DONE, 7'd1}},
      '{CMD_POP_LEFT,   '0, 1, 1'b0, 1'b1, '{'1, ST_DONE, 7'd0}},
      // fill to the top, then push on full at both ends
      '{CMD_PUSH_LEFT,  '0, 1, 1'b0, 1'b0, '{'0, ST_DONE, 7'd0}},
      '{CMD_PUSH_RIGHT, '0, 63, 1'b1, 1'b0, '{'0, ST_DONE, 7'd0}},
      '{CMD_PUSH_LEFT,  32'h5555_5555, 1, 1'b0, 1'b1, '{'0, ST_FULL, 7'd64}},
      '{CMD_PUSH_RIGHT, 32'haaaa_aaaa, 1, 1'b0, 1'b1, '{'0, ST_FULL, 7'd64}},
      '{CMD_POP_LEFT,   '0, 1, 1'b0, 1'b1, '{'0, ST_DONE, 7'd63}},
      '{CMD_PUSH_RIGHT, '0, 1, 1'b1, 1'b0, '{'0, ST_DONE, 7'd0}},
      // drain from the right, then empty pop
      '{CMD_POP_RIGHT,  '0, 64, 1'b0, 1'b0, '{'0, ST_DONE, 7'd0}},
      '{CMD_POP_RIGHT,  '0, 1, 1'b0, 1'b1, '{EmptyPopValue, ST_EMPTY, 7'd0}},
      // fill from the left, full, drain from the left
      '{CMD_PUSH_LEFT,  '0, 64, 1'b1, 1'b0, '{'0, ST_DONE, 7'd0}},
      '{CMD_PUSH_LEFT,  32'h0000_0001, 1, 1'b0, 1'b1, '{'0, ST_FULL, 7'd64}},
      '{CMD_POP_LEFT,   '0, 64, 1'b0, 1'b0, '{'0, ST_DONE, 7'd0}},
      '{CMD_POP_LEFT,   '0, 1, 1'b0, 1'b1, '{EmptyPopValue, ST_EMPTY, 7'd0}}
    };

    // Hold reset, then release it
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table
    foreach (dir_tab[r]) begin
      for (int unsigned k = 0; k < dir_tab[r].reps; k++) begin
        send_req(dir_tab[r].cmd, dir_tab[r].rnd ? pick_value() : dir_tab[r].value,
                 dir_tab[r].fixed, dir_tab[r].want);
      end
    end

    // Random runs in segments, most leaning toward pushes or pops to reach full and empty
    sent     = 0;
    seg_left = 0;
    push_bias = 50;
    while (sent < RandItems) begin
      if (seg_left == 0) begin
        seg_left = SegLen;
        case ($urandom_range(0, 4))
          0: push_bias = 90;
          1: push_bias = 10;
          2: push_bias = 50;
          3: push_bias = 97;
          default: push_bias = 3;
        endcase
      end
      steady_run = (sent >= 400) && (sent < 550);
      if ($urandom_range(0, 99) < push_bias) begin
        cmd = $urandom_range(0, 1) ? CMD_PUSH_RIGHT : CMD_PUSH_LEFT;
      end else begin
        cmd = $urandom_range(0, 1) ? CMD_POP_RIGHT : CMD_POP_LEFT;
      end
      send_req(cmd, pick_value(), 1'b0, '0);
      sent++;
      seg_left--;
    end
    steady_run = 1'b0;
    req.valid <= 1'b0;

    // Drain the responses still due, then let the pipeline settle
    while (due_rsp_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    if (fail_count == 0 && due_rsp_q.size() == 0) begin
      $display("double_ended_queue regression: pass");
    end else begin
      $display("double_ended_queue regression: fail");
    end
    $finish;
  end

endmodule
